### rtl/core/bmp24_pixel_stream_parser_assert.svh
// ---------------------------------------------------------------------------
// BMP parser assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ---------------------------------------------------------------------------
`ifndef BMP24_PIXEL_STREAM_PARSER_ASSERT_SVH
`define BMP24_PIXEL_STREAM_PARSER_ASSERT_SVH

// Same-cycle implication.
`define BMP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define BMP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bmp24p_pkg.sv
// ---------------------------------------------------------------------------
// BMP parser package
// Types, codes and header constants shared by the parser core and top level.
// ---------------------------------------------------------------------------
package bmp24p_pkg;

	localparam int MAX_DIM_DEF = 4096;

	// Header layout, byte offsets from the start of the file.
	localparam logic [5:0] POS_SIG0   = 6'd0;
	localparam logic [5:0] POS_SIG1   = 6'd1;
	localparam logic [5:0] POS_W0     = 6'd18;
	localparam logic [5:0] POS_W3     = 6'd21;
	localparam logic [5:0] POS_H0     = 6'd22;
	localparam logic [5:0] POS_H3     = 6'd25;
	localparam logic [5:0] POS_BPP0   = 6'd28;
	localparam logic [5:0] POS_BPP1   = 6'd29;
	localparam logic [5:0] POS_HDR_LAST = 6'd53;

	localparam logic [7:0]  CHAR_B = 8'h42;
	localparam logic [7:0]  CHAR_M = 8'h4D;
	localparam logic [15:0] BPP_24 = 16'd24;

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PIXEL,
		PH_PAD,
		PH_IDLE
	} phase_t;

	typedef enum logic [1:0] {
		ST_PIXEL,
		ST_BAD_SIG,
		ST_NOT_24,
		ST_TOO_BIG
	} status_t;

	typedef struct packed {
		logic    [11:0] pixel_x;
		logic    [11:0] pixel_y;
		logic    [7:0]  red;
		logic    [7:0]  green;
		logic    [7:0]  blue;
		status_t        status;
		logic           last;
	} result_t;

endpackage

### rtl/core/bmp24p_core.sv
// ---------------------------------------------------------------------------
// BMP parser core
// Header check, size capture and pixel assembly, one byte per accepted word.
// ---------------------------------------------------------------------------
module bmp24p_core
	import bmp24p_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_acc,
	input  logic [7:0]    in_byte,
	input  logic          in_start,
	output logic          res_valid,
	output result_t       res
);

`include "bmp24_pixel_stream_parser_assert.svh"

	localparam int CNT_W = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

	phase_t             phase_q, cur_phase, nxt_phase;
	logic [5:0]         pos_q, cur_pos, nxt_pos;
	logic [31:0]        width_q, cur_w, nxt_w;
	logic [31:0]        height_q, cur_h, nxt_h;
	logic [15:0]        bpp_q, cur_bpp, nxt_bpp;
	logic [CNT_W-1:0]   col_q, cur_col, nxt_col;
	logic [CNT_W-1:0]   row_q, cur_row, nxt_row;
	logic [1:0]         bip_q, cur_bip, nxt_bip;
	logic [7:0]         blue_q, cur_blue, nxt_blue;
	logic [7:0]         green_q, cur_green, nxt_green;
	logic [1:0]         pad_q, cur_pad, nxt_pad;
	logic               first_ok_q, cur_first_ok, nxt_first_ok;
	logic [CNT_W:0]     col_inc, row_inc;
	logic [15:0]        bpp_full;

	// A start-of-file word sees the reset state.
	always_comb begin
		cur_phase    = in_start ? PH_HEADER : phase_q;
		cur_pos      = in_start ? '0 : pos_q;
		cur_w        = in_start ? '0 : width_q;
		cur_h        = in_start ? '0 : height_q;
		cur_bpp      = in_start ? '0 : bpp_q;
		cur_col      = in_start ? '0 : col_q;
		cur_row      = in_start ? '0 : row_q;
		cur_bip      = in_start ? '0 : bip_q;
		cur_blue     = in_start ? '0 : blue_q;
		cur_green    = in_start ? '0 : green_q;
		cur_pad      = in_start ? '0 : pad_q;
		cur_first_ok = in_start ? 1'b0 : first_ok_q;
	end

	always_comb begin
		nxt_phase    = cur_phase;
		nxt_pos      = cur_pos;
		nxt_w        = cur_w;
		nxt_h        = cur_h;
		nxt_bpp      = cur_bpp;
		nxt_col      = cur_col;
		nxt_row      = cur_row;
		nxt_bip      = cur_bip;
		nxt_blue     = cur_blue;
		nxt_green    = cur_green;
		nxt_pad      = cur_pad;
		nxt_first_ok = cur_first_ok;
		res_valid    = 1'b0;
		res          = '0;
		col_inc      = {1'b0, cur_col} + 1'b1;
		row_inc      = {1'b0, cur_row} + 1'b1;
		bpp_full     = {in_byte, cur_bpp[7:0]};

		case (cur_phase)
			PH_HEADER: begin
				nxt_pos = cur_pos + 6'd1;
				if (cur_pos == POS_HDR_LAST) begin
					nxt_phase = (cur_w == '0 || cur_h == '0) ? PH_IDLE : PH_PIXEL;
				end
				case (cur_pos) inside
					POS_SIG0: begin
						nxt_first_ok = (in_byte == CHAR_B);
					end
					POS_SIG1: begin
						if (!(cur_first_ok && in_byte == CHAR_M)) begin
							res_valid  = 1'b1;
							res.status = ST_BAD_SIG;
							res.last   = 1'b1;
							nxt_phase  = PH_IDLE;
						end
					end
					// The byte lane is the header offset minus two, kept to two bits.
					[POS_W0:POS_W3]: begin
						nxt_w[{cur_pos[1:0] - 2'd2, 3'b000} +: 8] = in_byte;
					end
					[POS_H0:POS_H3]: begin
						nxt_h[{cur_pos[1:0] - 2'd2, 3'b000} +: 8] = in_byte;
					end
					POS_BPP0: begin
						nxt_bpp[7:0] = in_byte;
					end
					POS_BPP1: begin
						nxt_bpp = bpp_full;
						if (bpp_full != BPP_24) begin
							res_valid  = 1'b1;
							res.status = ST_NOT_24;
							res.last   = 1'b1;
							nxt_phase  = PH_IDLE;
						end else if (cur_w > 32'(MAX_DIM) || cur_h > 32'(MAX_DIM)) begin
							res_valid  = 1'b1;
							res.status = ST_TOO_BIG;
							res.last   = 1'b1;
							nxt_phase  = PH_IDLE;
						end
					end
					default: begin
					end
				endcase
			end
			PH_PIXEL: begin
				case (cur_bip)
					2'd0: begin
						nxt_blue = in_byte;
						nxt_bip  = 2'd1;
					end
					2'd1: begin
						nxt_green = in_byte;
						nxt_bip   = 2'd2;
					end
					default: begin
						nxt_bip      = 2'd0;
						res_valid    = 1'b1;
						res.pixel_x  = cur_w[11:0] - 12'd1 - 12'(cur_col);
						res.pixel_y  = 12'(cur_row);
						res.red      = in_byte;
						res.green    = cur_green;
						res.blue     = cur_blue;
						res.status   = ST_PIXEL;
						// Width and height are at most MAX_DIM here, so the low
						// bits carry the whole value.
						if (col_inc == cur_w[CNT_W:0]) begin
							nxt_col = '0;
							if (row_inc == cur_h[CNT_W:0]) begin
								res.last  = 1'b1;
								nxt_phase = PH_IDLE;
							end else begin
								nxt_row = row_inc[CNT_W-1:0];
								nxt_pad = cur_w[1:0];
								if (cur_w[1:0] != 2'd0) begin
									nxt_phase = PH_PAD;
								end
							end
						end else begin
							nxt_col = col_inc[CNT_W-1:0];
						end
					end
				endcase
			end
			PH_PAD: begin
				nxt_pad = cur_pad - 2'd1;
				if (cur_pad == 2'd1) begin
					nxt_phase = PH_PIXEL;
				end
			end
			default: begin
			end
		endcase

		if (!in_acc) begin
			res_valid = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HEADER;
			pos_q      <= '0;
			width_q    <= '0;
			height_q   <= '0;
			bpp_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			bip_q      <= '0;
			blue_q     <= '0;
			green_q    <= '0;
			pad_q      <= '0;
			first_ok_q <= 1'b0;
		end else if (in_acc) begin
			phase_q    <= nxt_phase;
			pos_q      <= nxt_pos;
			width_q    <= nxt_w;
			height_q   <= nxt_h;
			bpp_q      <= nxt_bpp;
			col_q      <= nxt_col;
			row_q      <= nxt_row;
			bip_q      <= nxt_bip;
			blue_q     <= nxt_blue;
			green_q    <= nxt_green;
			pad_q      <= nxt_pad;
			first_ok_q <= nxt_first_ok;
		end
	end

	`BMP_ASSERT_IMP(a_err_has_last, res_valid && (res.status != ST_PIXEL), res.last,
		"error result without last")
	`BMP_ASSERT_NXT(a_last_goes_idle, res_valid && res.last, phase_q == PH_IDLE,
		"parser not idle after final result")
	`BMP_ASSERT_IMP(a_idle_silent, in_acc && !in_start && (phase_q == PH_IDLE), !res_valid,
		"result produced while idle")
	`BMP_ASSERT_IMP(a_pixel_third_byte, res_valid && (res.status == ST_PIXEL),
		(cur_bip == 2'd2) && (cur_phase == PH_PIXEL), "pixel result not on red byte")

endmodule

### rtl/core/bmp24_pixel_stream_parser.sv
// ---------------------------------------------------------------------------
// 24-bit BMP pixel stream parser
// Parses a BMP file byte stream into mirrored-column pixel words.
// ---------------------------------------------------------------------------
// The input channel (s_axis) carries one byte of the file per word, with
// tuser marking the first byte of a new file, which restarts the parse.
// The 54-byte header is checked for the 'BM' signature and a bit count of
// 24, and the width and height are captured. Every blue, green, red triple
// after the header then produces one word on the output channel (m_axis)
// with its mirrored column and its row; row padding is skipped. A header
// error produces a single word carrying the error code in tuser, and the
// rest of the file is ignored until the next start marker. tlast is set on
// the final pixel and on every error word.
// A result is registered onto m_axis in the cycle after the byte that
// completes it is accepted. Throughput, with no output stall: one byte
// per clock, set by the single parse stage feeding one output register.
// Reset clears the parser to the start of a header and empties the output
// register. While the receiver stalls with a word pending, s_axis_tready
// follows m_axis_tready, so the held word is never overwritten.
module bmp24_pixel_stream_parser
	import bmp24p_pkg::*;
#(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic [0:0]  s_axis_tuser,   // [0] file_start
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [11:0] pixel_x, [23:12] pixel_y, [31:24] red, [39:32] green, [47:40] blue
	output logic [47:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // [1:0] status
	output logic        m_axis_tlast
);

	logic    in_acc;
	logic    res_valid;
	result_t res;
	logic    out_valid_q;
	result_t out_q;

	// A new byte is taken whenever the output register is empty or drains
	// in this same cycle.
	assign s_axis_tready = !out_valid_q || m_axis_tready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	bmp24p_core #(
		.MAX_DIM (MAX_DIM)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_acc    (in_acc),
		.in_byte   (s_axis_tdata),
		.in_start  (s_axis_tuser[0]),
		.res_valid (res_valid),
		.res       (res)
	);

	// Output register: loads whenever the input side may move.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {out_q.blue, out_q.green, out_q.red, out_q.pixel_y, out_q.pixel_x};
	assign m_axis_tuser  = out_q.status;
	assign m_axis_tlast  = out_q.last;

endmodule

### dv/tb_top.sv
// ---------------------------------------------------------------------------
// BMP parser testbench
// Streams whole and broken BMP files into the parser byte by byte, with
// random gaps on the input and random stalls on the output. A built-in
// parser model predicts the words that no directed file gives outright,
// and each received word is compared field by field with the oldest due.
// ---------------------------------------------------------------------------
module tb_top;
	import bmp24p_pkg::*;

	localparam int RANDOM_BYTES = 1000;
	localparam int HOLD_AT      = 500;     // receiver cycle at which the long stall starts
	localparam int HOLD_LEN     = 400;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int RUN_LIMIT    = 1000000; // cycles

	// One byte of the file as offered on the input channel.
	typedef struct packed {
		logic [7:0] data;
		logic       start;
		logic       typed;  // the word caused by this byte is given below
		result_t    want;
	} file_byte_t;

	// One directed file: header fields, how many bytes of it to send and
	// how many ignored bytes follow it.
	typedef struct packed {
		logic        start;
		logic [7:0]  sig0;
		logic [7:0]  sig1;
		logic [31:0] width;
		logic [31:0] height;
		logic [15:0] bpp;
		logic [15:0] cut;      // 0 sends the whole file
		logic [7:0]  trail;
		logic        const_fill;
		logic [7:0]  fill;
		logic        typed;    // want is the word caused by the last byte sent
		result_t     want;
	} file_row_t;

	localparam result_t BAD_SIG_WORD = '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0, ST_BAD_SIG, 1'b1};
	localparam result_t NOT_24_WORD  = '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0, ST_NOT_24, 1'b1};
	localparam result_t TOO_BIG_WORD = '{12'd0, 12'd0, 8'd0, 8'd0, 8'd0, ST_TOO_BIG, 1'b1};
	localparam result_t WHITE_WORD   = '{12'd0, 12'd0, 8'hFF, 8'hFF, 8'hFF, ST_PIXEL, 1'b1};
	localparam result_t BLACK_WORD   = '{12'd0, 12'd0, 8'h00, 8'h00, 8'h00, ST_PIXEL, 1'b1};
	localparam result_t NO_WORD      = '0;

	localparam file_row_t DIRECTED_FILES [16] = '{
		// First file straight after reset, without a start marker; bad second letter.
		'{1'b0, CHAR_B, 8'h58, 32'd1, 32'd1, BPP_24, 16'd2, 8'd3, 1'b0, 8'h00, 1'b1, BAD_SIG_WORD},
		'{1'b1, 8'h58, CHAR_M, 32'd1, 32'd1, BPP_24, 16'd2, 8'd0, 1'b0, 8'h00, 1'b1, BAD_SIG_WORD},
		'{1'b1, CHAR_B, CHAR_B, 32'd1, 32'd1, BPP_24, 16'd2, 8'd0, 1'b0, 8'h00, 1'b1, BAD_SIG_WORD},
		'{1'b1, CHAR_B, CHAR_M, 32'd8, 32'd8, 16'd32, 16'd30, 8'd4, 1'b0, 8'h00, 1'b1, NOT_24_WORD},
		'{1'b1, CHAR_B, CHAR_M, 32'd4097, 32'd1, BPP_24, 16'd30, 8'd0, 1'b0, 8'h00, 1'b1,
			TOO_BIG_WORD},
		'{1'b1, CHAR_B, CHAR_M, 32'd1, 32'd4097, BPP_24, 16'd30, 8'd0, 1'b0, 8'h00, 1'b1,
			TOO_BIG_WORD},
		// A wrong bit count wins over an oversized image.
		'{1'b1, CHAR_B, CHAR_M, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd30, 8'd0, 1'b0,
			8'h00, 1'b1, NOT_24_WORD},
		'{1'b1, CHAR_B, CHAR_M, 32'hFFFF_FFFF, 32'd2, BPP_24, 16'd30, 8'd0, 1'b0, 8'h00, 1'b1,
			TOO_BIG_WORD},
		// Empty images end the parse silently; the bytes after the header are ignored.
		'{1'b1, CHAR_B, CHAR_M, 32'd0, 32'd5, BPP_24, 16'd0, 8'd12, 1'b0, 8'h00, 1'b0, NO_WORD},
		'{1'b1, CHAR_B, CHAR_M, 32'd3, 32'd0, BPP_24, 16'd0, 8'd8, 1'b0, 8'h00, 1'b0, NO_WORD},
		// Single pixel images; the final padding is not awaited.
		'{1'b1, CHAR_B, CHAR_M, 32'd1, 32'd1, BPP_24, 16'd57, 8'd2, 1'b1, 8'hFF, 1'b1, WHITE_WORD},
		'{1'b1, CHAR_B, CHAR_M, 32'd1, 32'd1, BPP_24, 16'd57, 8'd0, 1'b1, 8'h00, 1'b1, BLACK_WORD},
		// Widest and tallest images that are allowed, cut off after their first pixels.
		'{1'b1, CHAR_B, CHAR_M, 32'd4096, 32'd1, BPP_24, 16'd60, 8'd0, 1'b0, 8'h00, 1'b0, NO_WORD},
		'{1'b1, CHAR_B, CHAR_M, 32'd1, 32'd4096, BPP_24, 16'd70, 8'd0, 1'b0, 8'h00, 1'b0, NO_WORD},
		// Restart in the middle of a pixel, then an image with three padding bytes per row.
		'{1'b1, CHAR_B, CHAR_M, 32'd5, 32'd3, BPP_24, 16'd72, 8'd0, 1'b0, 8'h00, 1'b0, NO_WORD},
		'{1'b1, CHAR_B, CHAR_M, 32'd7, 32'd2, BPP_24, 16'd0, 8'd0, 1'b0, 8'h00, 1'b0, NO_WORD}
	};

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;
	logic [0:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [47:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	file_byte_t file_bytes[$];
	result_t    words_due[$];
	int         bad_words;

	// Parser model state.
	logic [5:0]  hdr_pos;
	phase_t      parse_phase;
	logic [31:0] img_w;
	logic [31:0] img_h;
	logic [15:0] bit_count;
	logic [11:0] col;
	logic [11:0] row;
	logic [1:0]  pix_byte;
	logic [7:0]  blue_hold;
	logic [7:0]  green_hold;
	logic [1:0]  pad_left;
	logic        sig_b_seen;

	bmp24_pixel_stream_parser #(
		.MAX_DIM(MAX_DIM_DEF)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser),
		.m_axis_tlast (m_axis_tlast)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void clear_parser();
		hdr_pos     = '0;
		parse_phase = PH_HEADER;
		img_w       = '0;
		img_h       = '0;
		bit_count   = '0;
		col         = '0;
		row         = '0;
		pix_byte    = '0;
		blue_hold   = '0;
		green_hold  = '0;
		pad_left    = '0;
		sig_b_seen  = 1'b0;
	endfunction

	// Advances the parser model by one byte and gives the word it causes, if any.
	function automatic void parse_byte(input logic [7:0] b, input logic restart,
			output bit emits, output result_t word);
		logic [5:0]  pos;
		logic [31:0] mirrored;
		bit          failed;
		status_t     code;
		emits  = 1'b0;
		word   = '0;
		failed = 1'b0;
		code   = ST_PIXEL;
		if (restart)
			clear_parser();
		case (parse_phase)
		PH_HEADER: begin
			pos = hdr_pos;
			if (pos == POS_SIG0) begin
				sig_b_seen = (b == CHAR_B);
			end else if (pos == POS_SIG1) begin
				if (!(sig_b_seen && b == CHAR_M)) begin
					failed = 1'b1;
					code   = ST_BAD_SIG;
				end
			end else if (pos >= POS_W0 && pos <= POS_W3) begin
				img_w = img_w | (32'(b) << (8 * (pos - POS_W0)));
			end else if (pos >= POS_H0 && pos <= POS_H3) begin
				img_h = img_h | (32'(b) << (8 * (pos - POS_H0)));
			end else if (pos == POS_BPP0 || pos == POS_BPP1) begin
				bit_count = bit_count | (16'(b) << (8 * (pos - POS_BPP0)));
				// The bit count is judged first, then the size.
				if (pos == POS_BPP1) begin
					if (bit_count != BPP_24) begin
						failed = 1'b1;
						code   = ST_NOT_24;
					end else if (img_w > MAX_DIM_DEF || img_h > MAX_DIM_DEF) begin
						failed = 1'b1;
						code   = ST_TOO_BIG;
					end
				end
			end
			if (failed) begin
				emits       = 1'b1;
				word.status = code;
				word.last   = 1'b1;
				parse_phase = PH_IDLE;
			end else begin
				hdr_pos = pos + 6'd1;
				if (pos == POS_HDR_LAST)
					parse_phase = (img_w == 0 || img_h == 0) ? PH_IDLE : PH_PIXEL;
			end
		end
		PH_PIXEL: begin
			case (pix_byte)
			2'd0: begin
				blue_hold = b;
				pix_byte  = 2'd1;
			end
			2'd1: begin
				green_hold = b;
				pix_byte   = 2'd2;
			end
			default: begin
				pix_byte     = 2'd0;
				emits        = 1'b1;
				mirrored     = img_w - 32'd1 - 32'(col);
				word.pixel_x = mirrored[11:0];
				word.pixel_y = row;
				word.red     = b;
				word.green   = green_hold;
				word.blue    = blue_hold;
				word.status  = ST_PIXEL;
				word.last    = 1'b0;
				if (32'(col) + 32'd1 >= img_w) begin
					col = '0;
					if (32'(row) + 32'd1 >= img_h) begin
						word.last   = 1'b1;
						parse_phase = PH_IDLE;
					end else begin
						row      = row + 12'd1;
						pad_left = img_w[1:0];
						if (pad_left != 0)
							parse_phase = PH_PAD;
					end
				end else begin
					col = col + 12'd1;
				end
			end
			endcase
		end
		PH_PAD: begin
			pad_left = pad_left - 2'd1;
			if (pad_left == 0)
				parse_phase = PH_PIXEL;
		end
		default: ;
		endcase
	endfunction

	function automatic string word_text(input result_t r);
		return $sformatf("x=%0d y=%0d r=%02h g=%02h b=%02h status=%s last=%0b",
			r.pixel_x, r.pixel_y, r.red, r.green, r.blue, r.status.name(), r.last);
	endfunction

	// Appends one file to the byte stream. Only the header fields that the
	// parser looks at are set; all other header bytes are random.
	task automatic add_file(input logic start, input logic [7:0] sig0, input logic [7:0] sig1,
			input logic [31:0] w, input logic [31:0] h, input logic [15:0] bpp,
			input int cut, input int trail, input logic const_fill, input logic [7:0] fill,
			input logic typed, input result_t want, output int sent);
		logic [7:0] hdr [54];
		int         len;
		file_byte_t item;
		for (int k = 0; k < 54; k++)
			hdr[k] = 8'($urandom);
		hdr[POS_SIG0] = sig0;
		hdr[POS_SIG1] = sig1;
		for (int k = 0; k < 4; k++) begin
			hdr[POS_W0 + k] = w[8 * k +: 8];
			hdr[POS_H0 + k] = h[8 * k +: 8];
		end
		hdr[POS_BPP0] = bpp[7:0];
		hdr[POS_BPP1] = bpp[15:8];
		len = 54;
		if (w >= 1 && w <= MAX_DIM_DEF && h >= 1 && h <= MAX_DIM_DEF)
			len += h * (3 * w + w % 4);
		if (cut != 0)
			len = cut;
		for (int k = 0; k < len + trail; k++) begin
			item.data  = (k < 54) ? hdr[k] : (const_fill ? fill : 8'($urandom));
			item.start = (k == 0) && start;
			item.typed = typed && (k == len - 1);
			item.want  = want;
			file_bytes.insert(file_bytes.size(), item);
		end
		sent = len + trail;
	endtask

	// Receiver: mostly one of four stall patterns chosen at random, with one
	// long hold-off so the output word backs up into the input.
	initial begin
		int cycle;
		int mode;
		cycle = 0;
		mode  = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n) begin
				cycle++;
				if (cycle % 97 == 0)
					mode = $urandom_range(0, 3);
				if (cycle >= HOLD_AT && cycle < HOLD_AT + HOLD_LEN)
					m_axis_tready <= 1'b0;
				else begin
					case (mode)
					0: m_axis_tready <= 1'b1;
					1: m_axis_tready <= 1'($urandom_range(0, 1));
					2: m_axis_tready <= (cycle % 4 == 0);
					default: m_axis_tready <= ($urandom_range(0, 7) != 0);
					endcase
				end
			end
		end
	end

	// Output checker: every accepted word must match the oldest prediction.
	always @(posedge clk) begin
		result_t got;
		result_t due;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.pixel_x = m_axis_tdata[11:0];
			got.pixel_y = m_axis_tdata[23:12];
			got.red     = m_axis_tdata[31:24];
			got.green   = m_axis_tdata[39:32];
			got.blue    = m_axis_tdata[47:40];
			got.status  = status_t'(m_axis_tuser);
			got.last    = m_axis_tlast;
			if (words_due.size() == 0) begin
				bad_words++;
				if (bad_words <= 10)
					$display("unexpected word: %s", word_text(got));
			end else begin
				due = words_due.pop_front();
				if (got.pixel_x !== due.pixel_x || got.pixel_y !== due.pixel_y ||
						got.red !== due.red || got.green !== due.green ||
						got.blue !== due.blue || got.status !== due.status ||
						got.last !== due.last) begin
					bad_words++;
					if (bad_words <= 10)
						$display("word mismatch: expected %s, actual %s",
							word_text(due), word_text(got));
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT * 10);
		$display("FAILURE");
		$finish;
	end

	// Stimulus, sender and end of run.
	initial begin
		int         sent;
		int         rand_sent;
		int         pick;
		int         idx;
		int         burst_left;
		int         gap_left;
		int         drain;
		int         cut;
		int         trail;
		logic [7:0]  sig0;
		logic [7:0]  sig1;
		logic [31:0] w;
		logic [31:0] h;
		logic [15:0] bpp;
		file_byte_t  item;
		file_row_t   f;
		bit          emits;
		result_t     word;

		bad_words = 0;
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= '0;
		clear_parser();

		foreach (DIRECTED_FILES[i]) begin
			f = DIRECTED_FILES[i];
			add_file(f.start, f.sig0, f.sig1, f.width, f.height, f.bpp, int'(f.cut),
				int'(f.trail), f.const_fill, f.fill, f.typed, f.want, sent);
		end

		// Random files: most are well formed small images, the rest carry
		// header errors, are cut short, are empty or are plain noise.
		rand_sent = 0;
		while (rand_sent < RANDOM_BYTES) begin
			pick  = $urandom_range(0, 99);
			sig0  = CHAR_B;
			sig1  = CHAR_M;
			bpp   = BPP_24;
			cut   = 0;
			trail = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : 0;
			w     = $urandom_range(1, 9);
			h     = $urandom_range(1, 5);
			if (pick < 5)
				w = $urandom_range(10, 40);
			if (pick < 70) begin
				if ($urandom_range(0, 9) == 0)
					cut = $urandom_range(1, 53 + 3 * w * h);
			end else if (pick < 78) begin
				sig0 = $urandom_range(0, 1) ? CHAR_B : 8'($urandom);
				sig1 = $urandom_range(0, 1) ? CHAR_M : 8'($urandom);
				cut  = $urandom_range(2, 60);
			end else if (pick < 85) begin
				bpp = $urandom_range(0, 1) ? 16'($urandom) :
					BPP_24 ^ (16'd1 << $urandom_range(0, 15));
				cut = $urandom_range(30, 60);
			end else if (pick < 91) begin
				case ($urandom_range(0, 2))
				0: w = MAX_DIM_DEF + $urandom_range(1, 2);
				1: h = MAX_DIM_DEF + $urandom_range(1, 2);
				default: w = $urandom;
				endcase
				cut = $urandom_range(30, 70);
			end else if (pick < 93) begin
				// Widest allowed row, cut off after a few pixels.
				w   = MAX_DIM_DEF;
				cut = $urandom_range(60, 120);
			end else if (pick < 96) begin
				if ($urandom_range(0, 1))
					w = 0;
				else
					h = 0;
				trail = $urandom_range(0, 6);
			end
			if (pick >= 96) begin
				sent = $urandom_range(1, 12);
				for (int k = 0; k < sent; k++) begin
					item.data  = 8'($urandom);
					item.start = ($urandom_range(0, 7) == 0);
					item.typed = 1'b0;
					item.want  = NO_WORD;
					file_bytes.insert(file_bytes.size(), item);
				end
			end else begin
				add_file($urandom_range(0, 19) != 0, sig0, sig1, w, h, bpp, cut, trail,
					1'b0, 8'h00, 1'b0, NO_WORD, sent);
			end
			rand_sent += sent;
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Bursts of random length with random gaps; an offered byte is held
		// until it is taken.
		idx        = 0;
		burst_left = 0;
		gap_left   = 0;
		while (idx < file_bytes.size()) begin
			@(posedge clk);
			if (s_axis_tvalid && s_axis_tready) begin
				item = file_bytes[idx];
				parse_byte(item.data, item.start, emits, word);
				if (item.typed)
					words_due.insert(words_due.size(), item.want);
				else if (emits)
					words_due.insert(words_due.size(), word);
				idx++;
			end
			if (s_axis_tvalid && !s_axis_tready)
				continue;
			if (idx == file_bytes.size()) begin
				s_axis_tvalid <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				s_axis_tvalid <= 1'b0;
			end else begin
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= file_bytes[idx].data;
				s_axis_tuser  <= file_bytes[idx].start;
				if (burst_left > 0) begin
					burst_left--;
				end else begin
					burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300) :
						$urandom_range(0, 20);
					gap_left   = $urandom_range(1, 6);
				end
			end
		end

		drain = 0;
		while (words_due.size() != 0 && drain < DRAIN_LIMIT) begin
			@(posedge clk);
			drain++;
		end
		// A few more cycles so that any stray word still shows up.
		repeat (20) @(posedge clk);
		if (words_due.size() != 0) begin
			$display("%0d predicted words never arrived, next: %s", words_due.size(),
				word_text(words_due[0]));
			bad_words++;
		end
		if (bad_words == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### bmp24_pixel_stream_parser.f
+incdir+rtl/core
rtl/core/bmp24p_pkg.sv
rtl/core/bmp24p_core.sv
rtl/core/bmp24_pixel_stream_parser.sv
dv/tb_top.sv
